// ===== rtl/core/ldrf_pkg.sv =====
package ldrf_pkg;

  // default fraction width of the fixed-point format
  localparam int FRAC_BITS_DEF = 16;

  // field and datapath widths
  localparam int IN_W   = 32;
  localparam int REG_W  = 31;
  localparam int MAG_W  = 33;
  localparam int PROD_W = 2 * MAG_W;
  localparam int DEN_W  = 64;
  localparam int Q_W    = 33;

  // configuration register indexes
  localparam logic [1:0] CFG_ALPHA  = 2'd0;
  localparam logic [1:0] CFG_TARGET = 2'd1;
  localparam logic [1:0] CFG_TOL    = 2'd2;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== rtl/core/ldrf_mul.sv =====
module ldrf_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [ldrf_pkg::MAG_W-1:0]        op_a,
  input  logic [ldrf_pkg::MAG_W-1:0]        op_b,
  output logic [ldrf_pkg::PROD_W-1:0]       prod,
  output ldrf_pkg::unit_stat_t              stat
);

  localparam int CNT_W = $clog2(ldrf_pkg::MAG_W + 1);

  logic [ldrf_pkg::MAG_W-1:0] mcand;
  logic [ldrf_pkg::MAG_W-1:0] hi;
  logic [ldrf_pkg::MAG_W-1:0] lo;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic                       done;
  logic [ldrf_pkg::MAG_W:0]   sum;

  // add the multiplicand when the current multiplier bit is set
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);

  // shift-add, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        mcand <= op_a;
        hi    <= '0;
        lo    <= op_b;
      end else if (busy) begin
        {hi, lo} <= {sum, lo[ldrf_pkg::MAG_W-1:1]};
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_W'(ldrf_pkg::MAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod      = {hi, lo};
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/core/ldrf_div.sv =====
module ldrf_div #(
  parameter int NUM_W = 64 + ldrf_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [NUM_W-1:0]              num,
  input  logic [ldrf_pkg::DEN_W-1:0]    den,
  output logic [ldrf_pkg::Q_W-1:0]      quo,
  output logic                          ovf,
  output ldrf_pkg::unit_stat_t          stat
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]            num_sh;
  logic [ldrf_pkg::DEN_W-1:0]  dvs;
  logic [ldrf_pkg::DEN_W-1:0]  rem;
  logic [CNT_W-1:0]            cnt;
  logic                        busy;
  logic                        done;
  logic [ldrf_pkg::DEN_W:0]    trial;
  logic                        ge;

  // bring down the next numerator bit and test against the divisor
  assign trial = {rem, num_sh[NUM_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        num_sh <= num;
        dvs    <= den;
        rem    <= '0;
        quo    <= '0;
        ovf    <= 1'b0;
      end else if (busy) begin
        num_sh <= {num_sh[NUM_W-2:0], 1'b0};
        rem    <= ge ? ldrf_pkg::DEN_W'(trial - {1'b0, dvs})
                     : trial[ldrf_pkg::DEN_W-1:0];
        quo    <= {quo[ldrf_pkg::Q_W-2:0], ge};
        ovf    <= ovf | quo[ldrf_pkg::Q_W-1];
        cnt    <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/core/linear_distance_restraint_force_core.sv =====
// Linear pair-distance restraint: each transaction carries two 3-D positions
// in signed fixed point and returns the energy alpha/target*R, the force on
// the first site and the convergence flags, all saturated to their fields.
// One item is worked at a time; in_stall is low only while the core is idle.
// An item goes through three squares, the bit-pair square root, the target and
// energy products, the energy division and, per axis, a force product and a
// force division. When R is zero or on target the three force products and
// divisions are skipped. The shift-add multiplier and the restoring divider
// are each shared by all their products and quotients. A finished result waits
// in the output register while the next item is taken.
module linear_distance_restraint_force_core #(
  parameter int FRAC_BITS = ldrf_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [ldrf_pkg::REG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [31:0]          a_x,
  input  logic signed [31:0]          a_y,
  input  logic signed [31:0]          a_z,
  input  logic signed [31:0]          b_x,
  input  logic signed [31:0]          b_y,
  input  logic signed [31:0]          b_z,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [30:0]                 energy,
  output logic signed [31:0]          force_x,
  output logic signed [31:0]          force_y,
  output logic signed [31:0]          force_z,
  output logic                        converged,
  output logic                        stop_request
);

  localparam int NUM_W  = ldrf_pkg::DEN_W + FRAC_BITS;
  localparam int MAG_W  = ldrf_pkg::MAG_W;
  localparam int PROD_W = ldrf_pkg::PROD_W;
  localparam int Q_W    = ldrf_pkg::Q_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SQ_GO   = 4'd1;
  localparam logic [3:0] S_SQ_WAIT = 4'd2;
  localparam logic [3:0] S_SQRT    = 4'd3;
  localparam logic [3:0] S_TR_GO   = 4'd4;
  localparam logic [3:0] S_TR_WAIT = 4'd5;
  localparam logic [3:0] S_EM_GO   = 4'd6;
  localparam logic [3:0] S_EM_WAIT = 4'd7;
  localparam logic [3:0] S_ED_GO   = 4'd8;
  localparam logic [3:0] S_ED_WAIT = 4'd9;
  localparam logic [3:0] S_AX      = 4'd10;
  localparam logic [3:0] S_FM_GO   = 4'd11;
  localparam logic [3:0] S_FM_WAIT = 4'd12;
  localparam logic [3:0] S_FD_GO   = 4'd13;
  localparam logic [3:0] S_FD_WAIT = 4'd14;
  localparam logic [3:0] S_DONE    = 4'd15;

  localparam logic [Q_W-1:0] LIM_POS = Q_W'(32'h7FFF_FFFF);
  localparam logic [Q_W-1:0] LIM_NEG = Q_W'(32'h8000_0000);

  logic [3:0]                 state;
  logic [1:0]                 idx;
  logic [ldrf_pkg::REG_W-1:0] alpha_strength;
  logic [ldrf_pkg::REG_W-1:0] target_distance;
  logic [ldrf_pkg::REG_W-1:0] tolerance;
  logic                       stop_done;

  logic [MAG_W-1:0]           mag [3];
  logic [2:0]                 dneg;
  logic [PROD_W-1:0]          ssum;
  logic [PROD_W-1:0]          rad;
  logic [35:0]                rem;
  logic [MAG_W-1:0]           root;
  logic [5:0]                 cnt;
  logic [ldrf_pkg::DEN_W-1:0] tr;
  logic [30:0]                energy_r;
  logic [31:0]                frc [3];

  logic                       mul_start;
  logic [MAG_W-1:0]           mul_a;
  logic [MAG_W-1:0]           mul_b;
  logic [PROD_W-1:0]          mul_prod;
  ldrf_pkg::unit_stat_t       mul_stat;
  logic                       div_start;
  logic [NUM_W-1:0]           div_num;
  logic [ldrf_pkg::DEN_W-1:0] div_den;
  logic [Q_W-1:0]             div_q;
  logic                       div_ovf;
  ldrf_pkg::unit_stat_t       div_stat;

  logic [ldrf_pkg::REG_W-1:0] t_eff;
  logic                       far;
  logic                       skip_force;
  logic [MAG_W:0]             dev;
  logic                       conv;
  logic [35:0]                rem_sh;
  logic [35:0]                sq_trial;
  logic                       sq_ge;
  logic [32:0]                dif [3];
  logic [30:0]                e_sat;
  logic                       f_neg;
  logic [Q_W-1:0]             f_lim;
  logic [31:0]                f_mag;
  logic [31:0]                f_val;

  // treat a zero target as one LSB
  assign t_eff      = (target_distance == '0) ? ldrf_pkg::REG_W'(1) : target_distance;
  assign far        = root > MAG_W'(t_eff);
  assign skip_force = (root == '0) || (root == MAG_W'(t_eff));
  assign dev        = far ? ({1'b0, root} - (MAG_W + 1)'(t_eff))
                          : ((MAG_W + 1)'(t_eff) - {1'b0, root});
  assign conv       = dev < (MAG_W + 1)'(tolerance);

  // form the coordinate differences
  assign dif[0] = {a_x[31], a_x} - {b_x[31], b_x};
  assign dif[1] = {a_y[31], a_y} - {b_y[31], b_y};
  assign dif[2] = {a_z[31], a_z} - {b_z[31], b_z};

  // one square-root step: bring down two radicand bits
  assign rem_sh   = {rem[33:0], rad[PROD_W-1 -: 2]};
  assign sq_trial = {1'b0, root, 2'b01};
  assign sq_ge    = rem_sh >= sq_trial;

  // saturate the quotient for energy and force
  assign e_sat = (div_ovf || div_q > LIM_POS) ? 31'h7FFF_FFFF : div_q[30:0];
  assign f_neg = dneg[idx] != far;
  assign f_lim = f_neg ? LIM_NEG : LIM_POS;
  assign f_mag = (div_ovf || div_q > f_lim) ? f_lim[31:0] : div_q[31:0];
  assign f_val = f_neg ? (32'd0 - f_mag) : f_mag;

  // launch operands for the shared units
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      S_SQ_GO: begin
        mul_start = 1'b1;
        mul_a     = mag[idx];
        mul_b     = mag[idx];
      end
      S_TR_GO: begin
        mul_start = 1'b1;
        mul_a     = MAG_W'(t_eff);
        mul_b     = root;
      end
      S_EM_GO: begin
        mul_start = 1'b1;
        mul_a     = MAG_W'(alpha_strength);
        mul_b     = root;
      end
      S_ED_GO: begin
        div_start = 1'b1;
        div_num   = NUM_W'(mul_prod[ldrf_pkg::DEN_W-1:0]);
        div_den   = ldrf_pkg::DEN_W'(t_eff);
      end
      S_FM_GO: begin
        mul_start = 1'b1;
        mul_a     = MAG_W'(alpha_strength);
        mul_b     = mag[idx];
      end
      S_FD_GO: begin
        div_start = 1'b1;
        div_num   = {mul_prod[ldrf_pkg::DEN_W-1:0], {FRAC_BITS{1'b0}}};
        div_den   = tr;
      end
      default: begin
      end
    endcase
  end

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_strength  <= ldrf_pkg::REG_W'(65536);
      target_distance <= ldrf_pkg::REG_W'(65536);
      tolerance       <= ldrf_pkg::REG_W'(6554);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ldrf_pkg::CFG_ALPHA:  alpha_strength  <= cfg_data;
        ldrf_pkg::CFG_TARGET: target_distance <= cfg_data;
        ldrf_pkg::CFG_TOL:    tolerance       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequence one item through the serial units
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
      stop_done <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            for (int i = 0; i < 3; i++) begin
              dneg[i] <= dif[i][32];
              mag[i]  <= dif[i][32] ? (33'd0 - dif[i]) : dif[i];
            end
            ssum  <= '0;
            idx   <= '0;
            state <= S_SQ_GO;
          end
        end
        S_SQ_GO: state <= S_SQ_WAIT;
        S_SQ_WAIT: begin
          if (mul_stat.done) begin
            ssum <= ssum + mul_prod;
            if (idx == 2'd2) begin
              rad   <= ssum + mul_prod;
              rem   <= '0;
              root  <= '0;
              cnt   <= '0;
              state <= S_SQRT;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_SQ_GO;
            end
          end
        end
        S_SQRT: begin
          rem  <= sq_ge ? (rem_sh - sq_trial) : rem_sh;
          root <= {root[MAG_W-2:0], sq_ge};
          rad  <= {rad[PROD_W-3:0], 2'b00};
          cnt  <= cnt + 1'b1;
          if (cnt == 6'(MAG_W - 1)) begin
            state <= S_TR_GO;
          end
        end
        S_TR_GO: state <= S_TR_WAIT;
        S_TR_WAIT: begin
          if (mul_stat.done) begin
            tr    <= mul_prod[ldrf_pkg::DEN_W-1:0];
            state <= S_EM_GO;
          end
        end
        S_EM_GO: state <= S_EM_WAIT;
        S_EM_WAIT: begin
          if (mul_stat.done) begin
            state <= S_ED_GO;
          end
        end
        S_ED_GO: state <= S_ED_WAIT;
        S_ED_WAIT: begin
          if (div_stat.done) begin
            energy_r <= e_sat;
            idx      <= '0;
            state    <= S_AX;
          end
        end
        S_AX: begin
          if (skip_force) begin
            frc[idx] <= '0;
            if (idx == 2'd2) begin
              state <= S_DONE;
            end else begin
              idx <= idx + 1'b1;
            end
          end else begin
            state <= S_FM_GO;
          end
        end
        S_FM_GO: state <= S_FM_WAIT;
        S_FM_WAIT: begin
          if (mul_stat.done) begin
            state <= S_FD_GO;
          end
        end
        S_FD_GO: state <= S_FD_WAIT;
        S_FD_WAIT: begin
          if (div_stat.done) begin
            frc[idx] <= f_val;
            if (idx == 2'd2) begin
              state <= S_DONE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_AX;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            energy       <= energy_r;
            force_x      <= frc[0];
            force_y      <= frc[1];
            force_z      <= frc[2];
            converged    <= conv;
            stop_request <= conv && !stop_done;
            stop_done    <= stop_done | conv;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);

  ldrf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .prod  (mul_prod),
    .stat  (mul_stat)
  );

  ldrf_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_q),
    .ovf   (div_ovf),
    .stat  (div_stat)
  );

  // a stop request comes only with a converged result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && stop_request |-> converged)
    else $error("stop request without convergence");

  // a shown stop request has set the one-shot flag
  assert property (@(posedge clk) disable iff (rst)
    out_valid && stop_request |-> stop_done)
    else $error("stop request with flag clear");

  // arithmetic units are quiet while the core is idle
  assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !mul_stat.busy && !div_stat.busy)
    else $error("unit busy while idle");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;

  localparam int FRAC = ldrf_pkg::FRAC_BITS_DEF;
  localparam logic [127:0] SAT_POS = 128'h7FFF_FFFF;
  localparam logic [127:0] SAT_NEG = 128'h8000_0000;

  typedef struct {
    logic [30:0]        energy;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic               conv;
    logic               stop;
  } restraint_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = ldrf_pkg::CFG_ALPHA;
  logic [ldrf_pkg::REG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] a_x = '0, a_y = '0, a_z = '0;
  logic signed [31:0] b_x = '0, b_y = '0, b_z = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [30:0] energy;
  logic signed [31:0] force_x, force_y, force_z;
  logic converged, stop_request;

  // shadow of the register file and the one-shot stop flag
  logic [30:0] alpha_sh = 31'd65536;
  logic [30:0] target_sh = 31'd65536;
  logic [30:0] tol_sh = 31'd6554;
  logic stop_seen = 1'b0;

  restraint_t response_q[$];
  int errors = 0;
  int hold_cycles = 0;
  bit steady = 0;

  linear_distance_restraint_force_core uut (.*);

  always #6 clk = ~clk;

  initial begin
    #30000000;
    $display("tb: failure");
    $finish;
  end

  // Compute the restraint response of one pair and advance the stop flag.
  function automatic restraint_t restraint_response(
    logic signed [31:0] ax, logic signed [31:0] ay, logic signed [31:0] az,
    logic signed [31:0] bx, logic signed [31:0] by, logic signed [31:0] bz);
    restraint_t res;
    logic signed [32:0] dlt[3];
    logic [32:0] mag[3];
    logic [127:0] ssum, cand, rlen, tgt, alpha, quo, lim, fval, dev;
    logic far, neg;
    dlt[0] = $signed({ax[31], ax}) - $signed({bx[31], bx});
    dlt[1] = $signed({ay[31], ay}) - $signed({by[31], by});
    dlt[2] = $signed({az[31], az}) - $signed({bz[31], bz});
    ssum = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = dlt[i][32] ? 33'(-dlt[i]) : 33'(dlt[i]);
      ssum = ssum + 128'(mag[i]) * 128'(mag[i]);
    end
    // exact floor square root, one bit per step
    rlen = '0;
    for (int b = 34; b >= 0; b--) begin
      cand = rlen | (128'(1) << b);
      if (cand * cand <= ssum) rlen = cand;
    end
    tgt = (target_sh == 0) ? 128'(1) : 128'(target_sh);
    alpha = 128'(alpha_sh);
    quo = (alpha * rlen) / tgt;
    res.energy = (quo > SAT_POS) ? 31'h7FFF_FFFF : quo[30:0];
    far = rlen > tgt;
    for (int i = 0; i < 3; i++) begin
      fval = '0;
      neg = dlt[i][32] != far;
      if (rlen != 0 && rlen != tgt) begin
        quo = ((alpha * 128'(mag[i])) << FRAC) / (tgt * rlen);
        lim = neg ? SAT_NEG : SAT_POS;
        fval = (quo > lim) ? lim : quo;
        if (neg) fval = -fval;
      end
      if (i == 0) res.fx = fval[31:0];
      else if (i == 1) res.fy = fval[31:0];
      else res.fz = fval[31:0];
    end
    dev = far ? rlen - tgt : tgt - rlen;
    res.conv = dev < 128'(tol_sh);
    res.stop = res.conv && !stop_seen;
    if (res.conv) stop_seen = 1'b1;
    return res;
  endfunction

  // Offer one pair after a random gap (none in steady mode); hold it until the transaction is taken.
  task automatic send_pair(logic signed [31:0] ax, logic signed [31:0] ay,
                           logic signed [31:0] az, logic signed [31:0] bx,
                           logic signed [31:0] by, logic signed [31:0] bz);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    a_x <= ax; a_y <= ay; a_z <= az;
    b_x <= bx; b_y <= by; b_z <= bz;
    do @(posedge clk); while (in_stall);
    response_q.push_back(restraint_response(ax, ay, az, bx, by, bz));
  endtask

  // Drop valid, then wait until every expected result has come.
  task automatic drain;
    in_valid <= 1'b0;
    while (response_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ldrf_pkg::CFG_ALPHA:  alpha_sh = val;
      ldrf_pkg::CFG_TARGET: target_sh = val;
      ldrf_pkg::CFG_TOL:    tol_sh = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [30:0] alpha, logic [30:0] tgt, logic [30:0] tol);
    write_reg(ldrf_pkg::CFG_ALPHA, alpha);
    write_reg(ldrf_pkg::CFG_TARGET, tgt);
    write_reg(ldrf_pkg::CFG_TOL, tol);
  endtask

  // Draw one random pair; most sit near the target distance or close together.
  task automatic send_random_pair;
    logic signed [31:0] bx, by, bz, dx;
    int mode;
    bx = $urandom; by = $urandom; bz = $urandom;
    mode = $urandom_range(0, 3);
    case (mode)
      0: send_pair($urandom, $urandom, $urandom, bx, by, bz);
      1: send_pair(bx + $signed($urandom_range(0, 8191)) - 4096,
                   by + $signed($urandom_range(0, 8191)) - 4096,
                   bz + $signed($urandom_range(0, 8191)) - 4096, bx, by, bz);
      default: begin
        // one axis offset by roughly the target, sign random
        dx = $signed({1'b0, target_sh}) + $signed($urandom_range(0, 511)) - 256;
        if ($urandom_range(0, 1)) dx = -dx;
        bx = $signed($urandom) >>> 2;
        send_pair(bx + dx, by, bz, bx, by, bz);
      end
    endcase
  endtask

  // Receiver: random stall before each result (none in steady mode), plus requested long holds.
  initial begin
    int w;
    @(negedge rst);
    forever begin
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      w = steady ? 0 : $urandom_range(0, 9);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall) && hold_cycles == 0);
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    restraint_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (response_q.size() == 0) begin
        $display("%0t: unexpected result energy=%0d", $time, energy);
        errors++;
      end else begin
        exp_r = response_q.pop_front();
        if (energy !== exp_r.energy) begin
          $display("%0t: energy exp %0d got %0d", $time, exp_r.energy, energy);
          errors++;
        end
        if (force_x !== exp_r.fx) begin
          $display("%0t: force_x exp %0d got %0d", $time, exp_r.fx, force_x);
          errors++;
        end
        if (force_y !== exp_r.fy) begin
          $display("%0t: force_y exp %0d got %0d", $time, exp_r.fy, force_y);
          errors++;
        end
        if (force_z !== exp_r.fz) begin
          $display("%0t: force_z exp %0d got %0d", $time, exp_r.fz, force_z);
          errors++;
        end
        if (converged !== exp_r.conv) begin
          $display("%0t: converged exp %0b got %0b", $time, exp_r.conv, converged);
          errors++;
        end
        if (stop_request !== exp_r.stop) begin
          $display("%0t: stop_request exp %0b got %0b", $time, exp_r.stop,
                   stop_request);
          errors++;
        end
      end
    end
  end

  // Special pairs under the reset register values.
  task automatic test_directed;
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(32'sh0001_0000, 0, 0, 0, 0, 0);
    send_pair(0, 32'sh0001_0000, 0, 0, 0, 0);
    send_pair(0, 0, -32'sh0001_0800, 0, 0, 0);
    send_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_pair(1, 0, 0, 0, 0, 0);
    send_pair(0, -1, 1, 0, 0, 0);
    send_pair(32'sh0000_8000, -32'sh0000_4000, 32'sh0000_2000, 5, 7, -9);
    send_pair(32'sh1234_5678, 32'shEDCB_A987, 32'sh0F0F_0F0F, 0, 0, 0);
    send_pair(32'sh7FFF_FFFF, 0, 0, 32'sh7FFF_FFFF, 0, 1);
    drain();
  endtask

  // Register extremes, including a zero target and alpha extremes.
  task automatic test_register_extremes;
    set_regs(31'h7FFF_FFFF, 31'd1, 31'd0);
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(1, 0, 0, 0, 0, 0);
    send_pair(32'sh0001_0000, 32'sh0002_0000, 0, 0, 0, 0);
    send_pair(32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000, 0, 0);
    drain();
    set_regs(31'd0, 31'd0, 31'h7FFF_FFFF);
    send_pair(1, 0, 0, 0, 0, 0);
    send_pair(-5, 3, 2, 0, 0, 0);
    send_pair(32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, 0);
    drain();
    set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1);
    send_pair(32'sh7FFF_FFFF, 0, 0, 0, 0, 0);
    send_pair(32'sh7FFF_FFFF, 0, 0, -1, 0, 0);
    send_pair(0, 0, 3, 0, 0, 0);
    send_pair(-32'sh4000_0000, 32'sh4000_0000, 0, 32'sh4000_0000, 0, 0);
    drain();
  endtask

  // Hold off the receiver long enough that the core stalls its input.
  task automatic test_backpressure;
    set_regs(31'd131072, 31'd98304, 31'd3000);
    hold_cycles = 3000;
    repeat (2) @(posedge clk);
    for (int i = 0; i < 6; i++) send_random_pair();
    drain();
  endtask

  // Random pairs over several register settings.
  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 120 == 0) begin
        drain();
        case ((i / 120) % 4)
          0: set_regs(31'($urandom_range(0, 31'h7FFF_FFFF)),
                      31'($urandom_range(1, 31'h7FFF_FFFF)),
                      31'($urandom_range(0, 31'h7FFF_FFFF)));
          1: set_regs(31'($urandom_range(1, 1 << 20)), 31'($urandom_range(1 << 12, 1 << 20)),
                      31'($urandom_range(0, 1 << 10)));
          2: set_regs(31'h7FFF_FFFF, 31'($urandom_range(1, 1 << 18)),
                      31'($urandom_range(0, 255)));
          default: set_regs(31'($urandom_range(0, 1 << 17)), 31'($urandom_range(1, 1 << 24)),
                            31'($urandom_range(0, 1 << 14)));
        endcase
        steady = ((i / 120) == 2);
      end
      if (i == 300) drain();
      send_random_pair();
    end
    steady = 0;
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random(600);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
